// File: rtl/tlac_pkg.sv
package tlac_pkg;

    // sizes of the three tag rows
    localparam int L1_ENTRIES  = 8;
    localparam int L2_ENTRIES  = 16;
    localparam int L3_ENTRIES  = 32;
    localparam int ADDR_BITS   = 31;
    localparam int NUM_LVL     = 3;
    localparam int MAX_ENTRIES = (L3_ENTRIES > L2_ENTRIES)
                               ? ((L3_ENTRIES > L1_ENTRIES) ? L3_ENTRIES : L1_ENTRIES)
                               : ((L2_ENTRIES > L1_ENTRIES) ? L2_ENTRIES : L1_ENTRIES);

    // widths
    localparam int TAG_W      = ADDR_BITS;
    localparam int IDX_W      = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W      = 32;
    localparam int LVL_W      = 2;
    localparam int SHIFT_W    = 4;
    localparam int CAP1_W     = 4;
    localparam int CAP2_W     = 5;
    localparam int CAP3_W     = 6;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY = 3'd0,
        CFG_SHIFT  = 3'd1,
        CFG_L1_CAP = 3'd2,
        CFG_L2_CAP = 3'd3,
        CFG_L3_CAP = 3'd4
    } t_cfg_idx;

    // hit level codes
    localparam logic [LVL_W-1:0] HIT_NONE = 2'd3;

    // replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // probe sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_L1,
        ST_L2,
        ST_L3
    } t_state;

    // update command broadcast along one row of cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] fill;
        logic [IDX_W-1:0] from;
        logic [IDX_W-1:0] last;
    } t_row_ctl;

    function automatic int lvl_depth(input int lvl);
        int d;
        d = L1_ENTRIES;
        if (lvl == 1) d = L2_ENTRIES;
        if (lvl == 2) d = L3_ENTRIES;
        return d;
    endfunction

endpackage

// File: rtl/tlac_in_if.sv
interface tlac_in_if import tlac_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

// File: rtl/tlac_out_if.sv
interface tlac_out_if import tlac_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] hit_level;
    logic [CNT_W-1:0] l1_hit_count;
    logic [CNT_W-1:0] l1_miss_count;
    logic [CNT_W-1:0] l2_hit_count;
    logic [CNT_W-1:0] l2_miss_count;
    logic [CNT_W-1:0] l3_hit_count;
    logic [CNT_W-1:0] l3_miss_count;

    modport source (
        output valid, output hit_level,
        output l1_hit_count, output l1_miss_count,
        output l2_hit_count, output l2_miss_count,
        output l3_hit_count, output l3_miss_count,
        input  ready
    );
    modport sink (
        input  valid, input hit_level,
        input  l1_hit_count, input l1_miss_count,
        input  l2_hit_count, input l2_miss_count,
        input  l3_hit_count, input l3_miss_count,
        output ready
    );
endinterface

// File: rtl/tlac_cell.sv
module tlac_cell import tlac_pkg::*; (
    input  logic             i_clk,
    input  t_row_ctl         i_ctl,
    input  logic [IDX_W-1:0] i_pos,
    input  logic [TAG_W-1:0] i_tag,
    input  logic [TAG_W-1:0] i_next,
    output logic [TAG_W-1:0] o_data,
    output logic             o_match
);

    logic [TAG_W-1:0] r_data;

    // take the new tag at the youngest place, or the younger neighbor's entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_pos == i_ctl.last) begin
                r_data <= i_tag;
            end else if (i_pos >= i_ctl.from && i_pos < i_ctl.last) begin
                r_data <= i_next;
            end
        end
    end

    // entry is resident only below the fill count
    assign o_match = (i_pos < i_ctl.fill) && (r_data == i_tag);
    assign o_data  = r_data;

endmodule

// File: rtl/tlac_ctl.sv
module tlac_ctl import tlac_pkg::*; (
    input  logic             i_commit,
    input  logic             i_hit,
    input  logic             i_lru,
    input  logic [IDX_W-1:0] i_hit_idx,
    input  logic [IDX_W-1:0] i_fill,
    input  logic [IDX_W-1:0] i_limit,
    output t_row_ctl         o_ctl,
    output logic [IDX_W-1:0] o_next_fill
);

    logic w_evict;

    assign w_evict = (i_fill >= i_limit) && (i_fill != '0);

    // hit: move to youngest in lru mode; miss: append, dropping the oldest when full
    always_comb begin
        o_ctl.fill  = i_fill;
        o_ctl.en    = i_commit;
        o_ctl.from  = '0;
        o_ctl.last  = i_fill - IDX_W'(1);
        o_next_fill = i_fill;
        if (i_hit) begin
            o_ctl.en   = i_commit && i_lru;
            o_ctl.from = i_hit_idx;
        end else if (!w_evict) begin
            o_ctl.from  = i_fill;
            o_ctl.last  = i_fill;
            o_next_fill = i_fill + IDX_W'(1);
        end
    end

endmodule

// File: rtl/three_level_assoc_cache_tags.sv
// Three-level fully associative tag model with hit and miss counters.
// Input channel i_in carries one address per transaction; output channel o_out
// returns one result per address: the level that hit (3 when all missed) and
// the six running counters after this access.
// Each level is a row of tag cells, oldest entry at position zero; a row
// compares all its cells in parallel and shifts entries toward the head in the
// same cycle it is updated.
// Sequence: an address is taken in ST_IDLE, then ST_L1, ST_L2 and ST_L3 probe
// one level each, stopping at the first hit, and the final state registers the
// result. A new address is taken only back in ST_IDLE, but there even while a
// finished result still waits on o_out; if the receiver stalls, the last level
// holds its update until the output register is free.
// Configuration through i_cfg_we / i_cfg_idx / i_cfg_data is to be written only
// idle by the user; the block itself does not enforce this.
// Reset (synchronous, i_rst_n low): registers to lru, block shift 6, full
// capacities; fill counts and counters to zero; no clearing pass is needed.
module three_level_assoc_cache_tags import tlac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tlac_in_if.sink               i_in,
    tlac_out_if.source            o_out
);

    // configuration registers
    logic              r_policy;
    logic [SHIFT_W-1:0] r_shift;
    logic [CAP1_W-1:0] r_cap1;
    logic [CAP2_W-1:0] r_cap2;
    logic [CAP3_W-1:0] r_cap3;

    t_state             r_state, n_state;
    logic [TAG_W-1:0]   r_tag;
    logic [IDX_W-1:0]   r_fill     [NUM_LVL];
    logic [CNT_W-1:0]   r_hit_cnt  [NUM_LVL];
    logic [CNT_W-1:0]   r_miss_cnt [NUM_LVL];
    logic [CNT_W-1:0]   n_hit_cnt  [NUM_LVL];
    logic [CNT_W-1:0]   n_miss_cnt [NUM_LVL];

    logic               r_out_valid;
    logic [LVL_W-1:0]   r_out_level;
    logic [CNT_W-1:0]   r_out_hit  [NUM_LVL];
    logic [CNT_W-1:0]   r_out_miss [NUM_LVL];

    logic [TAG_W-1:0]   w_data  [NUM_LVL][MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] w_match [NUM_LVL];
    logic [IDX_W-1:0]   w_cap     [NUM_LVL];
    logic [IDX_W-1:0]   w_hit_idx [NUM_LVL];
    logic [IDX_W-1:0]   w_next_fill [NUM_LVL];
    logic [NUM_LVL-1:0] w_hit;
    logic [NUM_LVL-1:0] w_commit;
    t_row_ctl           w_ctl [NUM_LVL];

    logic               w_accept;
    logic               w_out_busy;
    logic               w_done;
    logic               w_go;
    logic               w_hit_cur;
    logic [LVL_W-1:0]   w_cur;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_LRU;
            r_shift  <= SHIFT_W'(6);
            r_cap1   <= CAP1_W'(8);
            r_cap2   <= CAP2_W'(16);
            r_cap3   <= CAP3_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLICY: r_policy <= i_cfg_data[0];
                CFG_SHIFT:  r_shift  <= i_cfg_data[SHIFT_W-1:0];
                CFG_L1_CAP: r_cap1   <= i_cfg_data[CAP1_W-1:0];
                CFG_L2_CAP: r_cap2   <= i_cfg_data[CAP2_W-1:0];
                CFG_L3_CAP: r_cap3   <= i_cfg_data[CAP3_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cap[0] = IDX_W'(r_cap1);
    assign w_cap[1] = IDX_W'(r_cap2);
    assign w_cap[2] = IDX_W'(r_cap3);

    // tag rows, one per level
    for (genvar l = 0; l < NUM_LVL; l++) begin : g_lvl
        localparam int DEPTH = lvl_depth(l);
        logic [IDX_W-1:0] w_limit;

        assign w_data[l][MAX_ENTRIES] = '0;

        for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
            if (k < DEPTH) begin : g_on
                tlac_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (w_ctl[l]),
                    .i_pos   (IDX_W'(k)),
                    .i_tag   (r_tag),
                    .i_next  (w_data[l][k+1]),
                    .o_data  (w_data[l][k]),
                    .o_match (w_match[l][k])
                );
            end else begin : g_off
                assign w_data[l][k]  = '0;
                assign w_match[l][k] = 1'b0;
            end
        end

        // capacity zero acts as one, and never beyond the row depth
        assign w_limit = (w_cap[l] == '0) ? IDX_W'(1)
                       : (w_cap[l] > IDX_W'(DEPTH)) ? IDX_W'(DEPTH) : w_cap[l];

        // position of the matching cell (at most one matches)
        always_comb begin
            w_hit_idx[l] = '0;
            for (int k = 0; k < MAX_ENTRIES; k++) begin
                if (w_match[l][k]) begin
                    w_hit_idx[l] = w_hit_idx[l] | IDX_W'(k);
                end
            end
        end

        assign w_hit[l] = |w_match[l];

        tlac_ctl u_ctl (
            .i_commit    (w_commit[l]),
            .i_hit       (w_hit[l]),
            .i_lru       (r_policy == POLICY_LRU),
            .i_hit_idx   (w_hit_idx[l]),
            .i_fill      (r_fill[l]),
            .i_limit     (w_limit),
            .o_ctl       (w_ctl[l]),
            .o_next_fill (w_next_fill[l])
        );
    end

    // probe sequencer
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_busy = r_out_valid && !o_out.ready;
    assign w_hit_cur  = w_hit[w_cur];
    assign w_done     = w_hit_cur || (r_state == ST_L3);

    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        w_cur       = LVL_W'(0);
        w_go        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) n_state = ST_L1;
            end
            ST_L1: begin
                w_cur = LVL_W'(0);
                w_go  = !(w_done && w_out_busy);
                if (w_go) n_state = w_done ? ST_IDLE : ST_L2;
            end
            ST_L2: begin
                w_cur = LVL_W'(1);
                w_go  = !(w_done && w_out_busy);
                if (w_go) n_state = w_done ? ST_IDLE : ST_L3;
            end
            ST_L3: begin
                w_cur = LVL_W'(2);
                w_go  = !w_out_busy;
                if (w_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        for (int l = 0; l < NUM_LVL; l++) begin
            w_commit[l]   = w_go && (w_cur == LVL_W'(l));
            n_hit_cnt[l]  = r_hit_cnt[l];
            n_miss_cnt[l] = r_miss_cnt[l];
            if (w_commit[l]) begin
                if (w_hit[l]) n_hit_cnt[l]  = r_hit_cnt[l] + CNT_W'(1);
                else          n_miss_cnt[l] = r_miss_cnt[l] + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // block address of the accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag <= i_in.address >> r_shift;
        end
    end

    // fill counts and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LVL; l++) begin
                r_fill[l]     <= '0;
                r_hit_cnt[l]  <= '0;
                r_miss_cnt[l] <= '0;
            end
        end else begin
            for (int l = 0; l < NUM_LVL; l++) begin
                if (w_commit[l]) r_fill[l] <= w_next_fill[l];
                r_hit_cnt[l]  <= n_hit_cnt[l];
                r_miss_cnt[l] <= n_miss_cnt[l];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_done) begin
            r_out_level <= w_hit_cur ? w_cur : HIT_NONE;
            for (int l = 0; l < NUM_LVL; l++) begin
                r_out_hit[l]  <= n_hit_cnt[l];
                r_out_miss[l] <= n_miss_cnt[l];
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hit_level     = r_out_level;
    assign o_out.l1_hit_count  = r_out_hit[0];
    assign o_out.l1_miss_count = r_out_miss[0];
    assign o_out.l2_hit_count  = r_out_hit[1];
    assign o_out.l2_miss_count = r_out_miss[1];
    assign o_out.l3_hit_count  = r_out_hit[2];
    assign o_out.l3_miss_count = r_out_miss[2];

    // a resident block sits in at most one cell of a row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match[0]) && $onehot0(w_match[1]) && $onehot0(w_match[2]))
        else $error("several cells of a row match one tag");

    // fill counts never pass the row depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= IDX_W'(L1_ENTRIES) && r_fill[1] <= IDX_W'(L2_ENTRIES)
        && r_fill[2] <= IDX_W'(L3_ENTRIES))
        else $error("fill count beyond row depth");

    // a hit in level one finishes the transaction and leaves level two untouched
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_L1 && w_go && w_hit[0]) |=>
        (r_state == ST_IDLE && r_out_valid && $stable(r_fill[1])))
        else $error("level one hit did not complete the transaction");

    // a result is only produced when the output register can take it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_done) |-> !w_out_busy)
        else $error("result overwrote a pending transaction");

endmodule

// File: verif/tlac_lookup_checker.sv
`timescale 1ns / 100ps

module tlac_lookup_checker import tlac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tlac_in_if                    i_in,
    tlac_out_if                   i_out,
    output int                    o_pending,
    output int                    o_errors
);

    // one predicted result: hit level plus counters after the access
    typedef struct packed {
        logic [LVL_W-1:0]                level;
        logic [NUM_LVL-1:0][CNT_W-1:0]   hits;
        logic [NUM_LVL-1:0][CNT_W-1:0]   misses;
    } t_outcome;

    // mirrored configuration
    logic               policy;
    logic [SHIFT_W-1:0] blk_shift;
    int                 cap [NUM_LVL];

    // tag rows, oldest entry at index zero
    logic [TAG_W-1:0]              rows [NUM_LVL][MAX_ENTRIES];
    int                            fill [NUM_LVL];
    logic [NUM_LVL-1:0][CNT_W-1:0] hit_cnt;
    logic [NUM_LVL-1:0][CNT_W-1:0] miss_cnt;

    t_outcome expected_outcomes [$];

    task automatic report_mismatch(input string msg);
        if (o_errors < 50)
            $display("%0t mismatch: %s", $realtime, msg);
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                               input logic [CNT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // probe one row; updates order, fill and counters, returns 1 on hit
    function automatic bit probe_row(input int lvl, input logic [TAG_W-1:0] blk);
        int depth;
        int n;
        int room;
        depth = (lvl == 0) ? L1_ENTRIES : (lvl == 1) ? L2_ENTRIES : L3_ENTRIES;
        n = (fill[lvl] > depth) ? depth : fill[lvl];
        room = (cap[lvl] == 0) ? 1 : cap[lvl];
        if (room > depth)
            room = depth;
        for (int i = 0; i < n; i++) begin
            if (rows[lvl][i] == blk) begin
                hit_cnt[lvl] = hit_cnt[lvl] + CNT_W'(1);
                // lru moves the block to the youngest place
                if (policy == POLICY_LRU) begin
                    for (int j = i; j < n - 1; j++)
                        rows[lvl][j] = rows[lvl][j + 1];
                    rows[lvl][n - 1] = blk;
                end
                fill[lvl] = n;
                return 1'b1;
            end
        end
        miss_cnt[lvl] = miss_cnt[lvl] + CNT_W'(1);
        // only the single oldest entry goes, even when fill exceeds capacity
        if (n >= room && n > 0) begin
            for (int j = 0; j < n - 1; j++)
                rows[lvl][j] = rows[lvl][j + 1];
            n = n - 1;
        end
        rows[lvl][n] = blk;
        fill[lvl] = n + 1;
        return 1'b0;
    endfunction

    function automatic logic [LVL_W-1:0] lookup_block(input logic [TAG_W-1:0] blk);
        for (int lvl = 0; lvl < NUM_LVL; lvl++)
            if (probe_row(lvl, blk))
                return lvl[LVL_W-1:0];
        return HIT_NONE;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            policy    = POLICY_LRU;
            blk_shift = 4'd6;
            cap[0]    = L1_ENTRIES;
            cap[1]    = L2_ENTRIES;
            cap[2]    = L3_ENTRIES;
            for (int lvl = 0; lvl < NUM_LVL; lvl++)
                fill[lvl] = 0;
            hit_cnt   = '0;
            miss_cnt  = '0;
            o_errors  = 0;
            expected_outcomes.delete();
        end else begin
            // register writes, low bits only, spare indexes ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY: policy    = i_cfg_data[0];
                    CFG_SHIFT:  blk_shift = i_cfg_data[SHIFT_W-1:0];
                    CFG_L1_CAP: cap[0]    = int'(i_cfg_data[CAP1_W-1:0]);
                    CFG_L2_CAP: cap[1]    = int'(i_cfg_data[CAP2_W-1:0]);
                    CFG_L3_CAP: cap[2]    = int'(i_cfg_data[CAP3_W-1:0]);
                    default: ;
                endcase
            end

            // result transaction against the oldest prediction
            if (i_out.valid && i_out.ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("result with no access pending");
                end else begin
                    want = expected_outcomes[0];
                    expected_outcomes.delete(0);
                    check_field("hit_level", CNT_W'(i_out.hit_level), CNT_W'(want.level));
                    check_field("l1_hit_count", i_out.l1_hit_count, want.hits[0]);
                    check_field("l1_miss_count", i_out.l1_miss_count, want.misses[0]);
                    check_field("l2_hit_count", i_out.l2_hit_count, want.hits[1]);
                    check_field("l2_miss_count", i_out.l2_miss_count, want.misses[1]);
                    check_field("l3_hit_count", i_out.l3_hit_count, want.hits[2]);
                    check_field("l3_miss_count", i_out.l3_miss_count, want.misses[2]);
                end
            end

            // address transaction: walk the levels and record the outcome
            if (i_in.valid && i_in.ready) begin
                want.level  = lookup_block(i_in.address >> blk_shift);
                want.hits   = hit_cnt;
                want.misses = miss_cnt;
                expected_outcomes = {expected_outcomes, want};
            end
        end
        o_pending = expected_outcomes.size();
    end

endmodule

// File: verif/tb_three_level_assoc_cache_tags.sv
`timescale 1ns / 100ps

module tb_three_level_assoc_cache_tags;
    import tlac_pkg::*;

    localparam int LIMIT     = 400000;
    localparam int SETTLE    = 8;
    localparam int POOL_SIZE = 64;
    localparam int PHASES    = 12;
    localparam int PHASE_LEN = 142;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    pending;
    int                    errors;
    int                    cycles = 0;
    bit                    steady = 1'b0;

    tlac_in_if  in_ch ();
    tlac_out_if out_ch ();

    three_level_assoc_cache_tags dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    tlac_lookup_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stalls at random unless in a steady stretch
    always @(posedge i_clk)
        out_ch.ready <= steady || ($urandom_range(99, 0) >= 36);

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb_three_level_assoc_cache_tags failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic pol, input logic [CFG_DATA_W-1:0] shift,
                                input logic [CFG_DATA_W-1:0] c1,
                                input logic [CFG_DATA_W-1:0] c2,
                                input logic [CFG_DATA_W-1:0] c3);
        write_reg(CFG_POLICY, {{(CFG_DATA_W-1){1'b0}}, pol});
        write_reg(CFG_SHIFT, shift);
        write_reg(CFG_L1_CAP, c1);
        write_reg(CFG_L2_CAP, c2);
        write_reg(CFG_L3_CAP, c3);
        i_cfg_we <= 1'b0;
    endtask

    // one address transaction, with random idle cycles ahead of it
    task automatic push_access(input logic [TAG_W-1:0] addr);
        while (!steady && $urandom_range(99, 0) < 36) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.address <= addr;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [TAG_W-1:0]   pool [POOL_SIZE];
        logic [TAG_W-1:0]   offs_mask;
        logic [TAG_W-1:0]   addr;
        logic [SHIFT_W-1:0] cur_shift;
        int                 ws;
        int                 k;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_POLICY;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.address <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: fill level one past capacity, then hit level two
        push_access(31'h0);
        push_access(31'h7FFF_FFFF);
        push_access(31'h3F);
        for (int b = 1; b <= 8; b++)
            push_access(TAG_W'(b) << 6);
        push_access(31'h0);
        push_access(31'h7FFF_FFC0);

        // spare index and an oversized policy value, zero capacities
        drain();
        write_reg(CFG_SPARE, '1);
        write_reg(CFG_POLICY, {{(CFG_DATA_W-1){1'b1}}, POLICY_FIFO});
        write_reg(CFG_SHIFT, '0);
        write_reg(CFG_L1_CAP, '0);
        write_reg(CFG_L2_CAP, '0);
        write_reg(CFG_L3_CAP, '0);
        i_cfg_we <= 1'b0;
        push_access(31'd5);
        push_access(31'd6);
        push_access(31'd5);
        push_access(31'd5);

        // capacities beyond the row depth, largest block shift
        drain();
        program_regs(POLICY_LRU, 6'd15, 6'd15, 6'd31, 6'd63);
        push_access(31'h0);
        push_access(31'h7FFF);
        push_access(31'h8000);
        push_access(31'h7FFF_8000);

        // capacity dropped below the current fill
        drain();
        program_regs(POLICY_LRU, 6'd15, 6'd2, 6'd2, 6'd2);
        push_access(31'h1_0000);
        push_access(31'h0);

        // random phases, each with its own settings and working set
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    cur_shift = 4'd0;
                    program_regs(POLICY_FIFO, 6'd0, 6'd1, 6'd1, 6'd1);
                end
                1: begin
                    cur_shift = 4'd15;
                    program_regs(POLICY_LRU, 6'd15, 6'd15, 6'd31, 6'd63);
                end
                2: begin
                    cur_shift = 4'd12;
                    program_regs(POLICY_LRU, 6'd12, 6'd8, 6'd16, 6'd32);
                end
                3: begin
                    cur_shift = 4'd6;
                    program_regs(POLICY_FIFO, 6'd6, 6'd8, 6'd16, 6'd32);
                end
                4: begin
                    cur_shift = 4'd3;
                    program_regs(POLICY_LRU, 6'd3, 6'd0, 6'd0, 6'd0);
                end
                default: begin
                    cur_shift = SHIFT_W'($urandom_range(15, 0));
                    program_regs(1'($urandom_range(1, 0)), CFG_DATA_W'(cur_shift),
                                 CFG_DATA_W'($urandom_range(15, 0)),
                                 CFG_DATA_W'($urandom_range(31, 0)),
                                 CFG_DATA_W'($urandom_range(63, 0)));
                end
            endcase
            steady = (ph == 2);

            for (int i = 0; i < POOL_SIZE; i++)
                pool[i] = TAG_W'($urandom);
            ws = $urandom_range(POOL_SIZE - 1, 1);
            offs_mask = ~({TAG_W{1'b1}} << cur_shift);

            // mostly reuse of a working set, some unrelated addresses
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(99, 0) < 20) begin
                    addr = TAG_W'($urandom);
                end else begin
                    k = $urandom_range(($urandom_range(3, 0) == 0) ? ws : ws / 4, 0);
                    addr = (pool[k] & ~offs_mask) | (TAG_W'($urandom) & offs_mask);
                end
                push_access(addr);
            end
            steady = 1'b0;
        end

        drain();
        if (errors == 0)
            $display("tb_three_level_assoc_cache_tags passed");
        else
            $display("tb_three_level_assoc_cache_tags failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tlac_pkg.sv
rtl/tlac_in_if.sv
rtl/tlac_out_if.sv
rtl/tlac_cell.sv
rtl/tlac_ctl.sv
rtl/three_level_assoc_cache_tags.sv
verif/tlac_lookup_checker.sv
verif/tb_three_level_assoc_cache_tags.sv
